/* rtl/core/tts_pkg.sv */
`timescale 1ns / 1ps
package tts_pkg;

  localparam int VAL_W = 40;

  typedef logic signed [VAL_W-1:0] val_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_SUB,
    ST_DIV_C,
    ST_DIV_D,
    ST_WR,
    ST_BS_RD,
    ST_BS_MUL,
    ST_BS_OUT
  } state_t;

  // Saturate an 82-bit signed value to the value range
  function automatic val_t sat82(input logic signed [81:0] v);
    logic signed [81:0] vmax;
    logic signed [81:0] vmin;
    vmax = 82'sd549755813887;
    vmin = -82'sd549755813888;
    if (v > vmax) begin
      sat82 = val_t'(vmax);
    end else if (v < vmin) begin
      sat82 = val_t'(vmin);
    end else begin
      sat82 = v[VAL_W-1:0];
    end
  endfunction

endpackage

/* rtl/core/tts_mul.sv */
`timescale 1ns / 1ps
// Bit-serial signed fixed-point multiplier: one multiplier bit per cycle.
module tts_mul
  import tts_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t op_a,
  input  val_t op_b,
  output logic done,
  output val_t prod
);

  localparam int CW = $clog2(VAL_W + 1);

  logic [79:0]   acc_r, acc_nxt;
  logic [79:0]   mcand_r, mcand_nxt;
  logic [VAL_W-1:0] mplier_r, mplier_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  val_t          prod_r, prod_nxt;

  logic [VAL_W-1:0] ma, mb;
  logic [79:0]   shifted;
  logic [81:0]   sres;

  always_comb begin
    ma = op_a[VAL_W-1] ? VAL_W'(-op_a) : op_a;
    mb = op_b[VAL_W-1] ? VAL_W'(-op_b) : op_b;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    prod_nxt   = prod_r;
    shifted    = acc_r >> FRAC_BITS;
    sres       = neg_r ? -{2'b00, shifted} : {2'b00, shifted};
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = {40'd0, ma};
      mplier_nxt = mb;
      neg_nxt    = op_a[VAL_W-1] ^ op_b[VAL_W-1];
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == CW'(VAL_W)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        prod_nxt = sat82(sres);
      end else begin
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    neg_r    <= neg_nxt;
    prod_r   <= prod_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

/* rtl/core/tts_div.sv */
`timescale 1ns / 1ps
// Restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle.
module tts_div
  import tts_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t num,
  input  val_t den,
  output logic done,
  output logic zero_den,
  output val_t quot
);

  localparam int NW = VAL_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [VAL_W:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0] d_r, d_nxt;
  logic             neg_r, neg_nxt;
  logic             nz_r, nz_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             zd_r, zd_nxt;
  val_t             quot_r, quot_nxt;

  logic [VAL_W-1:0] mn, md;
  logic [VAL_W:0]   trial;
  logic [81:0]      sres;

  always_comb begin
    mn = num[VAL_W-1] ? VAL_W'(-num) : num;
    md = den[VAL_W-1] ? VAL_W'(-den) : den;
    n_nxt = n_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    neg_nxt = neg_r; nz_nxt = nz_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0; zd_nxt = zd_r; quot_nxt = quot_r;
    trial = {rem_r[VAL_W-1:0], n_r[NW-1]};
    sres = neg_r ? -{{(82-NW){1'b0}}, q_r} : {{(82-NW){1'b0}}, q_r};
    if (start) begin
      n_nxt    = {mn, {FRAC_BITS{1'b0}}};
      q_nxt    = '0;
      rem_nxt  = '0;
      d_nxt    = md;
      neg_nxt  = num[VAL_W-1] ^ den[VAL_W-1];
      nz_nxt   = (num != '0);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      zd_nxt   = (den == '0);
    end else if (busy_r) begin
      if (cnt_r == CW'(NW)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // Zero divisor: sign of the numerator picks the rail; a zero numerator gives zero
        if (zd_r) begin
          if (!nz_r) quot_nxt = '0;
          else if (neg_r) quot_nxt = {1'b1, {(VAL_W-1){1'b0}}};
          else quot_nxt = {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          quot_nxt = sat82(sres);
        end
      end else begin
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = trial - {1'b0, d_r};
          q_nxt   = {q_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[NW-2:0], 1'b0};
        end
        n_nxt   = n_r << 1;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r <= n_nxt; q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; nz_r <= nz_nxt; zd_r <= zd_nxt; quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign zero_den = zd_r;
  assign quot     = quot_r;

endmodule

/* rtl/core/tridiagonal_thomas_solver.sv */
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)                                    | tuser | tlast
// in_     | in  | sub_diag, main_diag, super_diag, rhs_value (160 bits)| -     | last_row
// out_    | out | row_index, solution (48 bits incl. pad)               | singular | last_result
//
// A row runs two multiplies and then two divides in sequence, on the bit-serial
// multiplier and divider.
// Back substitution runs one multiply per result and waits out output stalls.
// rst_n is synchronous; it clears the row count, zero-pivot flag and sequencer.
// in_tready is low while a row or the back substitution is in progress.
module tridiagonal_thomas_solver
  import tts_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // sub_diag, main_diag, super_diag, rhs_value
  input  logic         in_tlast,   // last_row
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // row_index[5:0], solution[45:6], zero pad
  output logic         out_tuser,  // singular
  output logic         out_tlast   // last_result
);

  localparam int IW = $clog2(MAX_ROWS);

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          zps_r, zps_nxt;
  logic          last_r, last_nxt;
  val_t a_r, b_r, c_r, d_r, pc_r, pd_r, t_r, x_r;
  val_t num_r, cq_r;
  val_t pivot_w;
  logic          phase_r, phase_nxt;
  logic          ov_r, ov_nxt;
  logic [IW-1:0] oi_r;
  val_t          ox_r;
  logic          os_r, ol_r;

  // Stores for normalized c' and d'
  val_t sup_mem [MAX_ROWS];
  val_t rhs_mem [MAX_ROWS];
  val_t sup_rd_r, rhs_rd_r;
  logic [IW-1:0] rd_addr;

  logic mul_start, mul_done, div_start, div_done, div_zd;
  val_t mul_a, mul_b, mul_p, div_n, div_q;

  logic first_w, acc_in, acc_out, last_in;
  logic [81:0] diff;

  tts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_n), .den(pivot_w),
    .done(div_done), .zero_den(div_zd), .quot(div_q)
  );

  assign acc_in  = in_tvalid && in_tready;
  assign acc_out = out_tvalid && out_tready;
  assign first_w = (idx_r == '0);
  assign last_in = in_tlast || (idx_r == IW'(MAX_ROWS - 1));

  // Pivot b - a*c'[i-1], held while both divisions run
  assign pivot_w = sat82({{42{b_r[VAL_W-1]}}, b_r} - {{42{t_r[VAL_W-1]}}, t_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (acc_in) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_MUL;
      ST_MUL:    if (mul_done) state_nxt = phase_r ? ST_SUB : ST_MUL;
      ST_SUB:    state_nxt = ST_DIV_C;
      ST_DIV_C:  if (div_done) state_nxt = ST_DIV_D;
      ST_DIV_D:  if (div_done) state_nxt = ST_WR;
      ST_WR:     state_nxt = last_r ? ST_BS_OUT : ST_IDLE;
      ST_BS_RD:  state_nxt = ST_BS_MUL;
      ST_BS_MUL: if (mul_done) state_nxt = ST_BS_OUT;
      ST_BS_OUT: begin
        if (!ov_r) state_nxt = ST_BS_OUT;
        else if (acc_out) state_nxt = (oi_r == '0) ? ST_IDLE : ST_BS_RD;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE) && !ov_r;
    mul_start = 1'b0;
    mul_a     = a_r;
    mul_b     = phase_r ? pd_r : pc_r;
    div_start = 1'b0;
    div_n     = c_r;
    unique case (state_r)
      ST_RD:     begin mul_start = 1'b1; mul_b = first_w ? '0 : sup_rd_r; end
      ST_MUL:    begin mul_start = mul_done && !phase_r; mul_b = pd_r; end
      ST_SUB:    div_start = 1'b1;
      ST_DIV_C:  begin div_start = div_done; div_n = num_r; end
      ST_BS_MUL: begin mul_a = sup_rd_r; mul_b = x_r; mul_start = 1'b0; end
      default:   ;
    endcase
    if (state_r == ST_BS_RD) begin
      mul_start = 1'b1;
      mul_a = sup_rd_r;
      mul_b = x_r;
    end
    if (state_r == ST_DIV_D) div_n = num_r;
  end

  assign rd_addr = (state_r == ST_BS_OUT) ? IW'(oi_r - 1'b1) :
                   (state_r == ST_BS_RD || state_r == ST_BS_MUL) ? oi_r :
                   IW'(idx_r - 1'b1);
  assign diff    = {{42{rhs_rd_r[VAL_W-1]}}, rhs_rd_r} - {{42{mul_p[VAL_W-1]}}, mul_p};

  // Datapath and output register
  always_comb begin
    idx_nxt = idx_r; zps_nxt = zps_r; last_nxt = last_r; phase_nxt = phase_r;
    ov_nxt = ov_r;
    if (acc_out) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (acc_in) begin last_nxt = last_in; phase_nxt = 1'b0; end
      ST_MUL:   if (mul_done) phase_nxt = 1'b1;
      ST_DIV_C: if (div_done && div_zd) zps_nxt = 1'b1;
      ST_DIV_D: if (div_done && div_zd) zps_nxt = 1'b1;
      ST_WR:    begin
        if (!last_r) idx_nxt = idx_r + 1'b1;
        ov_nxt = last_r;
      end
      ST_BS_MUL: if (mul_done) ov_nxt = 1'b1;
      ST_BS_OUT: if (ov_r && acc_out && oi_r == '0) begin
        idx_nxt = '0;
        zps_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      zps_r   <= 1'b0;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      zps_r   <= zps_nxt;
      ov_r    <= ov_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
    end
    // Payload capture
    if (acc_in) begin
      a_r <= first_w ? '0 : in_tdata[39:0];
      b_r <= in_tdata[79:40];
      c_r <= last_in ? '0 : in_tdata[119:80];
      d_r <= in_tdata[159:120];
    end
    if (state_r == ST_RD) begin
      pc_r <= first_w ? '0 : sup_rd_r;
      pd_r <= first_w ? '0 : rhs_rd_r;
    end
    if (state_r == ST_MUL && mul_done && !phase_r) t_r <= mul_p;
    if (state_r == ST_SUB) begin
      num_r   <= sat82({{42{d_r[VAL_W-1]}}, d_r} - {{42{mul_p[VAL_W-1]}}, mul_p});
    end
    if (state_r == ST_DIV_C && div_done) cq_r <= div_q;
    if (state_r == ST_WR) begin
      sup_mem[idx_r] <= cq_r;
      rhs_mem[idx_r] <= div_q;
      x_r  <= div_q;
      ox_r <= div_q;
      oi_r <= idx_r;
      os_r <= zps_r;
      ol_r <= (idx_r == '0);
    end
    // Back substitution step: x = d'[i] - c'[i]*x
    if (state_r == ST_BS_MUL && mul_done) begin
      x_r  <= sat82(diff);
      ox_r <= sat82(diff);
      os_r <= zps_r;
      ol_r <= (oi_r == '0);
    end
    if (state_r == ST_BS_OUT && ov_r && acc_out) oi_r <= oi_r - 1'b1;
    sup_rd_r <= sup_mem[rd_addr];
    rhs_rd_r <= rhs_mem[rd_addr];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ox_r, 6'(oi_r)};
  assign out_tuser  = os_r;
  assign out_tlast  = ol_r;

  // Assertions
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (oi_r == '0)) else $error("last on nonzero row");
  a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

endmodule

/* tb/tb_tridiagonal_thomas_solver.sv */
`timescale 1ns / 1ps
module tb_tridiagonal_thomas_solver;
  import tts_pkg::*;

  localparam int ROWS_MAX = 64;
  localparam int FRAC = 24;
  localparam logic signed [39:0] POS_FULL = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] NEG_FULL = 40'sh8000000000;
  localparam logic signed [39:0] ONE_Q = 40'sh0001000000;

  typedef struct packed {
    logic [5:0]        row_index;
    logic signed [39:0] solution;
    logic              singular;
    logic              last_result;
  } soln_t;

  typedef struct {
    logic signed [39:0] a;
    logic signed [39:0] b;
    logic signed [39:0] c;
    logic signed [39:0] d;
    logic               last;
    logic               has_exp;
    logic signed [39:0] exp_x;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  tridiagonal_thomas_solver i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Solver model state
  logic signed [39:0] cp_store [ROWS_MAX];
  logic signed [39:0] dp_store [ROWS_MAX];
  int unsigned rows_seen = 0;
  bit pivot_zero = 0;
  soln_t pending_solns[$];
  int errors = 0;
  int mismatches = 0;
  bit hold_sink = 0;
  int hold_cycles = 0;
  bit calm = 0;
  bit running = 1;

  function automatic logic signed [39:0] clamp(input logic signed [127:0] v);
    if (v > 128'sd549755813887) return POS_FULL;
    if (v < -128'sd549755813888) return NEG_FULL;
    return v[39:0];
  endfunction

  // Product truncated toward zero
  function automatic logic signed [39:0] qmul(input logic signed [39:0] x,
                                              input logic signed [39:0] y);
    logic signed [127:0] p;
    logic [127:0] m;
    p = 128'(x) * 128'(y);
    m = p < 0 ? 128'(-p) : 128'(p);
    m = m >> FRAC;
    return clamp(p < 0 ? -$signed(m) : $signed(m));
  endfunction

  function automatic logic signed [39:0] qdiv(input logic signed [39:0] n,
                                              input logic signed [39:0] dv);
    logic signed [127:0] nn, dd, q;
    if (dv == 0) begin
      pivot_zero = 1;
      if (n == 0) return '0;
      return n > 0 ? POS_FULL : NEG_FULL;
    end
    nn = 128'(n) <<< FRAC;
    dd = 128'(dv);
    q = nn / dd;  // truncates toward zero
    return clamp(q);
  endfunction

  // Forward sweep for one row, back substitution on the last one
  task automatic solve_row(input row_t r);
    int unsigned idx;
    bit first, fin;
    logic signed [39:0] a, c, pc, pd, piv, num, x;
    soln_t s;
    idx = rows_seen;
    first = (idx == 0);
    fin = r.last || (idx == ROWS_MAX - 1);
    a = first ? '0 : r.a;
    c = fin ? '0 : r.c;
    pc = first ? '0 : cp_store[idx-1];
    pd = first ? '0 : dp_store[idx-1];
    piv = clamp(128'(r.b) - 128'(qmul(a, pc)));
    num = clamp(128'(r.d) - 128'(qmul(a, pd)));
    cp_store[idx] = qdiv(c, piv);
    dp_store[idx] = qdiv(num, piv);
    if (!fin) begin
      rows_seen = idx + 1;
      return;
    end
    x = dp_store[idx];
    for (int i = idx; i >= 0; i--) begin
      if (i < idx) x = clamp(128'(dp_store[i]) - 128'(qmul(cp_store[i], x)));
      s.row_index = i[5:0];
      s.solution = x;
      s.singular = pivot_zero;
      s.last_result = (i == 0);
      pending_solns.push_back(s);
    end
    rows_seen = 0;
    pivot_zero = 0;
  endtask

  function automatic logic signed [39:0] rnd_val();
    logic signed [39:0] v;
    case ($urandom_range(0, 5))
      0: v = 40'({$urandom, $urandom});
      1: v = POS_FULL;
      2: v = NEG_FULL;
      3: v = '0;
      default: v = $signed(40'($urandom_range(0, 32'h07FFFFFF))) - 40'sh0004000000;
    endcase
    return v;
  endfunction

  // Push one row through the input handshake
  task automatic send_row(input row_t r);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 38) @(negedge clk);
    in_tdata <= {r.d, r.c, r.b, r.a};
    in_tlast <= r.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    solve_row(r);
    if (r.has_exp && r.last && pending_solns.size() == 1)
      pending_solns[0].solution = r.exp_x;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Receiver side ready
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    soln_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.row_index = out_tdata[5:0];
      got.solution = out_tdata[45:6];
      got.singular = out_tuser;
      got.last_result = out_tlast;
      if (pending_solns.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected item: %p", got);
      end else begin
        want = pending_solns.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  task automatic drain();
    while (pending_solns.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_system(input int n);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r.a = rnd_val(); r.b = rnd_val(); r.c = rnd_val(); r.d = rnd_val();
      if ($urandom_range(0, 3) != 0) r.b = ONE_Q * 40'($urandom_range(2, 9));
      if ($urandom_range(0, 19) == 0) r.b = '0;
      r.last = (i == n - 1);
      r.has_exp = 0;
      send_row(r);
    end
  endtask

  row_t plan[$];

  initial begin
    row_t r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-row systems with known answers, extremes, zero pivots
    r = '{a:POS_FULL, b:ONE_Q, c:POS_FULL, d:ONE_Q, last:1, has_exp:1, exp_x:ONE_Q};
    plan.push_back(r);
    r = '{a:'0, b:'0, c:'0, d:ONE_Q, last:1, has_exp:1, exp_x:POS_FULL};
    plan.push_back(r);
    r = '{a:'0, b:'0, c:'0, d:NEG_FULL, last:1, has_exp:1, exp_x:NEG_FULL};
    plan.push_back(r);
    r = '{a:'0, b:'0, c:'0, d:'0, last:1, has_exp:1, exp_x:'0};
    plan.push_back(r);
    r = '{a:NEG_FULL, b:NEG_FULL, c:NEG_FULL, d:POS_FULL, last:1, has_exp:0, exp_x:'0};
    plan.push_back(r);
    r = '{a:'0, b:40'sh0000000001, c:'0, d:POS_FULL, last:1, has_exp:1, exp_x:POS_FULL};
    plan.push_back(r);
    // Three-row system with a zero pivot in the middle
    r = '{a:POS_FULL, b:ONE_Q, c:ONE_Q, d:ONE_Q, last:0, has_exp:0, exp_x:'0};
    plan.push_back(r);
    r = '{a:ONE_Q, b:ONE_Q, c:NEG_FULL, d:POS_FULL, last:0, has_exp:0, exp_x:'0};
    plan.push_back(r);
    r = '{a:NEG_FULL, b:POS_FULL, c:POS_FULL, d:NEG_FULL, last:1, has_exp:0, exp_x:'0};
    plan.push_back(r);
    foreach (plan[i]) send_row(plan[i]);
    drain();

    // Full-size system: row 64 closes it without a last marker
    for (int i = 0; i < ROWS_MAX; i++) begin
      r.a = rnd_val(); r.b = ONE_Q * 4; r.c = rnd_val(); r.d = rnd_val();
      r.last = 0; r.has_exp = 0;
      send_row(r);
    end
    drain();

    // Stall the receiver long while rows keep coming
    hold_cycles = 3000;
    send_system(6);
    send_system(3);
    drain();

    // Random systems, mostly short
    while (1) begin
      int n;
      static int total = 0;
      if (total > 115) break;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      if (total > 60 && total < 90) calm = 1; else calm = 0;
      send_system(n);
      total += n;
    end
    calm = 0;
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
